FILE: rtl/ebdb_pkg.sv
// ----------------------------------------------------------------------------
// ebdb_pkg
// Types and fixed widths shared by the button debounce modules.
// ----------------------------------------------------------------------------
package ebdb_pkg;

   // width of the button fields on the ports
   localparam int unsigned FIELD_W  = 8;
   // width of the period register write data
   localparam int unsigned PERIOD_W = 16;

   // previous and next debounced level of the visible buttons
   typedef struct packed {
      logic [FIELD_W-1:0] prev;
      logic [FIELD_W-1:0] next;
   } lane_edges_type;

   // one result word
   typedef struct packed {
      logic [FIELD_W-1:0] debounced;
      logic [FIELD_W-1:0] pressed_flags;
      logic [FIELD_W-1:0] released_flags;
   } rsp_word_type;

endpackage

FILE: rtl/ebdb_lane.sv
// ----------------------------------------------------------------------------
// ebdb_lane
// One button: saturating integrator counter and its debounced level.
// ----------------------------------------------------------------------------
module ebdb_lane #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  raw_level,
   input  logic [COUNT_BITS-1:0] period,
   output logic                  level_prev,
   output logic                  level_next
);
   import ebdb_pkg::*;

   logic [COUNT_BITS-1:0] counter_ff;
   logic [COUNT_BITS-1:0] counter_in;
   logic                  level_ff;
   logic                  level_in;

   always_comb begin
      if (raw_level) begin
         // a counter above a lowered period snaps back to it
         if (counter_ff < period) begin
            counter_in = counter_ff + COUNT_BITS'(1);
         end else begin
            counter_in = period;
         end
      end else if (counter_ff != '0) begin
         counter_in = counter_ff - COUNT_BITS'(1);
      end else begin
         counter_in = '0;
      end

      if (counter_in == '0) begin
         level_in = 1'b0;
      end else if (counter_in >= period) begin
         level_in = 1'b1;
      end else begin
         level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         level_ff   <= 1'b0;
      end else if (advance) begin
         counter_ff <= counter_in;
         level_ff   <= level_in;
      end
   end

   assign level_prev = level_ff;
   assign level_next = level_in;

`ifndef NO_ASSERTIONS
   a_zero_count_low: assert property (@(posedge clock) disable iff (reset)
      (counter_ff == '0) |-> !level_ff)
      else $error("lane level high with empty counter");

   a_level_holds: assert property (@(posedge clock) disable iff (reset)
      (!$past(advance) && !$past(reset)) |-> $stable(level_ff))
      else $error("lane level changed without a tick");
`endif

endmodule

FILE: rtl/ebdb_merge.sv
// ----------------------------------------------------------------------------
// ebdb_merge
// Combines the lane levels into sticky press and release flags.
// ----------------------------------------------------------------------------
module ebdb_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ebdb_pkg::lane_edges_type      edges,
   input  logic [ebdb_pkg::FIELD_W-1:0]  press_clear_mask,
   input  logic [ebdb_pkg::FIELD_W-1:0]  release_clear_mask,
   output ebdb_pkg::rsp_word_type        word_in
);
   import ebdb_pkg::*;

   logic [FIELD_W-1:0] press_ff;
   logic [FIELD_W-1:0] press_in;
   logic [FIELD_W-1:0] release_ff;
   logic [FIELD_W-1:0] release_in;
   logic [FIELD_W-1:0] change;

   // clears go first, then this tick's edges
   always_comb begin
      change     = edges.prev ^ edges.next;
      press_in   = (press_ff & ~press_clear_mask) | (edges.next & change);
      release_in = (release_ff & ~release_clear_mask) | (~edges.next & change);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= '0;
         release_ff <= '0;
      end else if (advance) begin
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

   assign word_in.debounced      = edges.next;
   assign word_in.pressed_flags  = press_in;
   assign word_in.released_flags = release_in;

endmodule

FILE: rtl/ebdb_out_buf.sv
// ----------------------------------------------------------------------------
// ebdb_out_buf
// Output register with a skid stage between the tick and result channels.
// ----------------------------------------------------------------------------
module ebdb_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ebdb_pkg::rsp_word_type word_in,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ebdb_pkg::rsp_word_type word_out
);
   import ebdb_pkg::*;

   rsp_word_type out_word_ff;
   logic         out_valid_ff;
   rsp_word_type skid_word_ff;
   logic         skid_valid_ff;
   logic         out_free;

   // output slot can load when empty or its word leaves this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_word_ff <= skid_word_ff;
         end else if (push) begin
            out_word_ff <= word_in;
         end
      end else if (push) begin
         skid_word_ff <= word_in;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign word_out  = out_word_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output slot");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!skid_valid_ff && push && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("word pushed during stall was not kept in skid");
`endif

endmodule

FILE: rtl/eight_button_integrator_debounce.sv
// ----------------------------------------------------------------------------
// eight_button_integrator_debounce
// Integrator debounce of eight buttons with sticky press and release flags.
// ----------------------------------------------------------------------------
// Each word on the req channel is one tick: raw button levels plus masks that
// clear the sticky press and release flags before the tick's edges merge in.
// Every button lane runs a saturating counter against debounce_period, so all
// lanes advance in the same cycle and a new tick is taken every clock while
// req_stall is low. The rsp channel returns one word per tick: debounced
// levels and both sets of sticky flags after that tick.
// The result word is registered in the output register, or in the skid stage.
// Throughput: one tick per cycle while req_stall is low.
// When the receiver stalls, the word waits in the output register and one more
// tick is caught in a skid stage; req_stall rises only when the skid is full.
// The csr channel writes debounce_period (always ready); write it only while
// no tick is in flight. A period of zero acts as one, and a period larger than
// the counter can hold is clipped to the counter maximum.
// Synchronous reset clears counters, levels, flags and the result channel and
// sets the period to one.
// ----------------------------------------------------------------------------
module eight_button_integrator_debounce #(
   parameter int unsigned NUM_BUTTONS = 8,
   parameter int unsigned COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_raw_buttons,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_press_clear_mask,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_release_clear_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ebdb_pkg::FIELD_W-1:0]  rsp_debounced,
   output logic [ebdb_pkg::FIELD_W-1:0]  rsp_pressed_flags,
   output logic [ebdb_pkg::FIELD_W-1:0]  rsp_released_flags,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ebdb_pkg::PERIOD_W-1:0] csr_wdata
);
   import ebdb_pkg::*;

   localparam int unsigned WIDE_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
   localparam logic [WIDE_W:0] CNT_MAX =
      ((WIDE_W+1)'(1) << COUNT_BITS) - (WIDE_W+1)'(1);

   logic [COUNT_BITS-1:0] period_ff;
   logic [COUNT_BITS-1:0] period_in;
   logic [WIDE_W:0]       period_wide;
   logic                  advance;
   logic [FIELD_W-1:0]    prev_vec;
   logic [FIELD_W-1:0]    next_vec;
   lane_edges_type        edges;
   rsp_word_type          word_in;
   rsp_word_type          word_out;

   // clip the written period once, at write time
   always_comb begin
      period_wide = (WIDE_W+1)'(csr_wdata);
      if (csr_wdata == '0) begin
         period_wide = (WIDE_W+1)'(1);
      end else if (period_wide > CNT_MAX) begin
         period_wide = CNT_MAX;
      end
      period_in = period_wide[COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= COUNT_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         period_ff <= period_in;
      end
   end

   assign csr_ready = 1'b1;
   assign advance   = req_valid && !req_stall;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic raw_bit;
      logic lvl_prev;
      logic lvl_next;

      if (i < FIELD_W) begin : g_vis
         assign raw_bit     = req_raw_buttons[i];
         assign prev_vec[i] = lvl_prev;
         assign next_vec[i] = lvl_next;
      end else begin : g_hid
         assign raw_bit = 1'b0;
      end

      ebdb_lane #(
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .raw_level  (raw_bit),
         .period     (period_ff),
         .level_prev (lvl_prev),
         .level_next (lvl_next)
      );
   end

   // field bits with no button behind them stay low
   for (genvar j = NUM_BUTTONS; j < FIELD_W; j++) begin : g_unused
      assign prev_vec[j] = 1'b0;
      assign next_vec[j] = 1'b0;
   end

   assign edges.prev = prev_vec;
   assign edges.next = next_vec;

   ebdb_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .edges              (edges),
      .press_clear_mask   (req_press_clear_mask),
      .release_clear_mask (req_release_clear_mask),
      .word_in            (word_in)
   );

   ebdb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .word_in   (word_in),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .word_out  (word_out)
   );

   assign rsp_debounced      = word_out.debounced;
   assign rsp_pressed_flags  = word_out.pressed_flags;
   assign rsp_released_flags = word_out.released_flags;

`ifndef NO_ASSERTIONS
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_ff != '0)
      else $error("effective debounce period is zero");
`endif

endmodule

FILE: test/ebdb_tick_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ebdb_tick_checker
// Watches the tick, result and period channels of the button debounce block,
// predicts every result word from the accepted ticks and compares field by
// field against the words that leave the block.
// ----------------------------------------------------------------------------
module ebdb_tick_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_raw_buttons,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_press_clear_mask,
   input  logic [ebdb_pkg::FIELD_W-1:0]  req_release_clear_mask,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [ebdb_pkg::FIELD_W-1:0]  rsp_debounced,
   input  logic [ebdb_pkg::FIELD_W-1:0]  rsp_pressed_flags,
   input  logic [ebdb_pkg::FIELD_W-1:0]  rsp_released_flags,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ebdb_pkg::PERIOD_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import ebdb_pkg::*;

   localparam int LANES = 8;

   logic [PERIOD_W-1:0] period_reg;
   logic [15:0]         lane_count [LANES];
   logic [FIELD_W-1:0]  level_q;
   logic [FIELD_W-1:0]  press_q;
   logic [FIELD_W-1:0]  release_q;
   rsp_word_type        expected_words [$];

   // one tick of all eight integrators plus the sticky flag update
   task automatic integrate_tick(input logic [FIELD_W-1:0] raw, input logic [FIELD_W-1:0] pclr,
                                 input logic [FIELD_W-1:0] rclr, output rsp_word_type word);
      logic [15:0]        limit;
      logic [FIELD_W-1:0] nxt;
      logic [FIELD_W-1:0] change;
      // counter and register are both 16 bits, so no clipping of the period
      limit = (period_reg == '0) ? 16'd1 : period_reg;
      nxt   = level_q;
      for (int i = 0; i < LANES; i++) begin
         if (raw[i]) begin
            if (lane_count[i] < limit) lane_count[i] = lane_count[i] + 16'd1;
            else lane_count[i] = limit;
         end else if (lane_count[i] != 16'd0) begin
            lane_count[i] = lane_count[i] - 16'd1;
         end
         if (lane_count[i] == 16'd0) nxt[i] = 1'b0;
         else if (lane_count[i] >= limit) nxt[i] = 1'b1;
      end
      change    = level_q ^ nxt;
      press_q   = (press_q & ~pclr) | (nxt & change);
      release_q = (release_q & ~rclr) | (~nxt & change);
      level_q   = nxt;
      word.debounced      = level_q;
      word.pressed_flags  = press_q;
      word.released_flags = release_q;
   endtask

   task automatic flag_error(input string what, input logic [FIELD_W-1:0] exp_v,
                             input logic [FIELD_W-1:0] act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type word;
      if (reset) begin
         fail_count = 0;
         period_reg = 16'd1;
         for (int i = 0; i < LANES; i++) lane_count[i] = 16'd0;
         level_q   = '0;
         press_q   = '0;
         release_q = '0;
         expected_words.delete();
      end else begin
         // results first: a word leaving now belongs to an older tick
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result word with no tick outstanding: %02h %02h %02h", $time,
                           rsp_debounced, rsp_pressed_flags, rsp_released_flags);
            end else begin
               want = expected_words.pop_front();
               if (rsp_debounced !== want.debounced)
                  flag_error("debounced", want.debounced, rsp_debounced);
               if (rsp_pressed_flags !== want.pressed_flags)
                  flag_error("pressed_flags", want.pressed_flags, rsp_pressed_flags);
               if (rsp_released_flags !== want.released_flags)
                  flag_error("released_flags", want.released_flags, rsp_released_flags);
            end
         end
         if (csr_valid && csr_ready) period_reg = csr_wdata;
         if (req_valid && !req_stall) begin
            integrate_tick(req_raw_buttons, req_press_clear_mask, req_release_clear_mask, word);
            expected_words.push_back(word);
         end
      end
      pending <= expected_words.size();
   end

endmodule

FILE: test/eight_button_integrator_debounce_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_button_integrator_debounce_tb
// Drives ticks and period writes into the button debounce block with random
// gaps and receiver stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module eight_button_integrator_debounce_tb;
   import ebdb_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FIELD_W-1:0]  req_raw_buttons = '0;
   logic [FIELD_W-1:0]  req_press_clear_mask = '0;
   logic [FIELD_W-1:0]  req_release_clear_mask = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [FIELD_W-1:0]  rsp_debounced;
   logic [FIELD_W-1:0]  rsp_pressed_flags;
   logic [FIELD_W-1:0]  rsp_released_flags;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PERIOD_W-1:0] csr_wdata = '0;

   int                  fail_count;
   int                  pending;
   bit                  calm = 1'b0;
   int unsigned         cur_period = 1;
   logic [FIELD_W-1:0]  target = '0;
   int                  hold = 0;

   eight_button_integrator_debounce u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_raw_buttons        (req_raw_buttons),
      .req_press_clear_mask   (req_press_clear_mask),
      .req_release_clear_mask (req_release_clear_mask),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_debounced          (rsp_debounced),
      .rsp_pressed_flags      (rsp_pressed_flags),
      .rsp_released_flags     (rsp_released_flags),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_wdata              (csr_wdata)
   );

   ebdb_tick_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_raw_buttons        (req_raw_buttons),
      .req_press_clear_mask   (req_press_clear_mask),
      .req_release_clear_mask (req_release_clear_mask),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_debounced          (rsp_debounced),
      .rsp_pressed_flags      (rsp_pressed_flags),
      .rsp_released_flags     (rsp_released_flags),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_wdata              (csr_wdata),
      .fail_count             (fail_count),
      .pending                (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver stalls in bursts until the calm part of the run
   initial begin
      int len;
      forever begin
         len = $urandom_range(1, 16);
         if (!calm && $urandom_range(0, 2) == 0) rsp_stall <= 1'b1;
         else rsp_stall <= 1'b0;
         repeat (len) begin
            @(posedge clock);
            // a burst in progress ends as soon as the calm part starts
            if (calm) rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tick(input logic [FIELD_W-1:0] raw, input logic [FIELD_W-1:0] pclr,
                            input logic [FIELD_W-1:0] rclr);
      req_valid              <= 1'b1;
      req_raw_buttons        <= raw;
      req_press_clear_mask   <= pclr;
      req_release_clear_mask <= rclr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // let every outstanding word come back before touching the period
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_period(input logic [PERIOD_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      cur_period = value;
      @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_clear_mask();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5) return '0;
      if (sel == 8) return '1;
      if (sel == 9) return FIELD_W'($urandom_range(0, 255) & $urandom_range(0, 255));
      return FIELD_W'($urandom_range(0, 255));
   endfunction

   // buttons hold a level for a while, with occasional bounce on top
   task automatic run_random(input int count);
      int                 span;
      logic [FIELD_W-1:0] noise;
      for (int n = 0; n < count; n++) begin
         if (hold == 0) begin
            span   = (cur_period == 0) ? 1 : ((cur_period > 20) ? 20 : cur_period);
            target = target ^ FIELD_W'($urandom_range(0, 255));
            hold   = $urandom_range(1, 3 * span + 2);
         end
         hold--;
         noise = '0;
         if ($urandom_range(0, 3) == 0)
            noise = FIELD_W'($urandom_range(0, 255) & $urandom_range(0, 255));
         if (!calm && $urandom_range(0, 7) == 0) pause_req($urandom_range(1, 16));
         send_tick(target ^ noise, pick_clear_mask(), pick_clear_mask());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset period of one: edges and mask extremes
      send_tick(8'h00, 8'h00, 8'h00);
      send_tick(8'hFF, 8'h00, 8'h00);
      send_tick(8'hFF, 8'h00, 8'h00);
      send_tick(8'h00, 8'hFF, 8'h00);
      send_tick(8'h00, 8'h00, 8'hFF);
      send_tick(8'hAA, 8'hFF, 8'hFF);
      send_tick(8'h55, 8'h00, 8'h00);
      send_tick(8'h00, 8'h55, 8'hAA);
      send_tick(8'hFF, 8'hFF, 8'hFF);
      send_tick(8'h00, 8'hFF, 8'hFF);

      // zero period behaves as one
      set_period(16'd0);
      send_tick(8'h0F, 8'h00, 8'h00);
      send_tick(8'h00, 8'h00, 8'h00);
      send_tick(8'hF0, 8'hFF, 8'hFF);

      // saturate at five, then lower the period under the counters
      set_period(16'd5);
      repeat (6) send_tick(8'hFF, 8'h00, 8'h00);
      set_period(16'd2);
      send_tick(8'h00, 8'h00, 8'h00);
      send_tick(8'hFF, 8'h00, 8'h00);
      send_tick(8'h00, 8'h00, 8'h00);
      send_tick(8'h00, 8'h00, 8'h00);

      set_period(16'hFFFF);
      send_tick(8'hFF, 8'hFF, 8'h00);
      send_tick(8'hFF, 8'h00, 8'hFF);

      set_period(16'd2);
      run_random(80);
      set_period(16'd3);
      run_random(80);
      set_period(16'd1);
      run_random(70);
      set_period(16'd0);
      run_random(50);
      set_period(16'd7);
      run_random(90);
      set_period(16'hFFFF);
      run_random(30);
      set_period(PERIOD_W'($urandom_range(1, 12)));
      run_random(80);
      set_period(16'd4);
      run_random(70);

      // no random idling on either side from here on
      calm = 1'b1;
      set_period(16'd3);
      run_random(100);

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
